// ===== design/zlbm_pkg.sv =====
// shared types, widths, codes and reset values for the zoned log bucket mapper
package zlbm_pkg;

  // sizes of the mapped space
  localparam int MAX_ZONES       = 256;
  localparam int MAX_SLOTS       = 1024;
  localparam int NUM_BUCKETS_DEF = 4096;

  // field widths
  localparam int KIND_W   = 2;
  localparam int BUCKET_W = 12;
  localparam int ZONE_W   = 8;
  localparam int SLOT_W   = 10;
  localparam int LOC_W    = 48;
  localparam int NZ_W     = 9;
  localparam int SPZ_W    = 11;
  localparam int BB_W     = 21;
  localparam int STRIDE_W = 35;
  localparam int BASE_W   = 40;
  localparam int FRAC_W   = 9;
  localparam int ENTRY_W  = 1 + ZONE_W + SLOT_W;

  // stream and register port widths
  localparam int S_TDATA_W = 16;
  localparam int M_TDATA_W = 72;
  localparam int APB_DW    = 64;
  localparam int APB_AW    = 6;
  localparam int REG_IDX_W = 3;

  // result bit positions in m_tdata
  localparam int OB_OK     = 0;
  localparam int OB_UNM    = 1;
  localparam int OB_ZONE   = 2;
  localparam int OB_SLOT   = OB_ZONE + ZONE_W;
  localparam int OB_LOC    = OB_SLOT + SLOT_W;
  localparam int OB_RST    = OB_LOC + LOC_W;
  localparam int OB_FIN    = OB_RST + 1;
  localparam int OB_CLEAN  = OB_FIN + 1;

  // request kinds
  localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ERASE = 2'd2;
  localparam logic [KIND_W-1:0] KIND_INVAL = 2'd3;

  // register indexes
  localparam logic [REG_IDX_W-1:0] REG_NUM_ZONES  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_SLOTS      = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_BUCKET_B   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_STRIDE     = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_BASE       = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_CLEAN_FRAC = 3'd5;

  // register reset values
  localparam logic [NZ_W-1:0]     RST_NUM_ZONES = 9'd256;
  localparam logic [SPZ_W-1:0]    RST_SLOTS     = 11'd1024;
  localparam logic [BB_W-1:0]     RST_BUCKET_B  = 21'd4096;
  localparam logic [STRIDE_W-1:0] RST_STRIDE    = 35'd4194304;
  localparam logic [BASE_W-1:0]   RST_BASE      = 40'd0;
  localparam logic [FRAC_W-1:0]   RST_FRAC      = 9'd26;

  typedef struct packed {
    logic [NZ_W-1:0]     nz;
    logic [SPZ_W-1:0]    spz;
    logic [BB_W-1:0]     bb;
    logic [STRIDE_W-1:0] stride;
    logic [BASE_W-1:0]   base;
    logic [FRAC_W-1:0]   frac;
  } cfg_t;

  typedef struct packed {
    logic valid;
    logic [ZONE_W-1:0] zone;
    logic [SLOT_W-1:0] slot;
  } map_entry_t;

  typedef struct packed {
    logic clr_we;
    logic load;
    logic rd_en;
    logic exec;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic out_full;
  } dp_status_t;

endpackage

// ===== design/zlbm_ram.sv =====
// generic single write port ram with registered read
module zlbm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/zlbm_regs.sv =====
// apb configuration registers with clamping and geometry restart pulse
module zlbm_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [zlbm_pkg::APB_AW-1:0]  paddr,
  input  logic [zlbm_pkg::APB_DW-1:0]  pwdata,
  output logic [zlbm_pkg::APB_DW-1:0]  prdata,
  output logic                         pready,
  output zlbm_pkg::cfg_t               cfg,
  output logic                         restart
);
  import zlbm_pkg::*;

  logic                 wr;
  logic [REG_IDX_W-1:0] reg_idx;

  function automatic logic [NZ_W-1:0] clamp_nz(input logic [NZ_W-1:0] v);
    logic [NZ_W-1:0] r;
    r = v;
    if (v < NZ_W'(2)) r = NZ_W'(2);
    if (v > NZ_W'(MAX_ZONES)) r = NZ_W'(MAX_ZONES);
    return r;
  endfunction

  function automatic logic [SPZ_W-1:0] clamp_spz(input logic [SPZ_W-1:0] v);
    logic [SPZ_W-1:0] r;
    r = v;
    if (v < SPZ_W'(1)) r = SPZ_W'(1);
    if (v > SPZ_W'(MAX_SLOTS)) r = SPZ_W'(MAX_SLOTS);
    return r;
  endfunction

  assign wr      = psel & penable & pwrite;
  assign reg_idx = paddr[APB_AW-1:3];
  assign pready  = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.nz     <= RST_NUM_ZONES;
      cfg.spz    <= RST_SLOTS;
      cfg.bb     <= RST_BUCKET_B;
      cfg.stride <= RST_STRIDE;
      cfg.base   <= RST_BASE;
      cfg.frac   <= RST_FRAC;
      restart    <= 1'b0;
    end else begin
      restart <= wr && (reg_idx == REG_NUM_ZONES || reg_idx == REG_SLOTS);
      if (wr) begin
        case (reg_idx)
          REG_NUM_ZONES:  cfg.nz     <= clamp_nz(pwdata[NZ_W-1:0]);
          REG_SLOTS:      cfg.spz    <= clamp_spz(pwdata[SPZ_W-1:0]);
          REG_BUCKET_B:   cfg.bb     <= pwdata[BB_W-1:0];
          REG_STRIDE:     cfg.stride <= pwdata[STRIDE_W-1:0];
          REG_BASE:       cfg.base   <= pwdata[BASE_W-1:0];
          REG_CLEAN_FRAC: begin
            cfg.frac <= (pwdata[FRAC_W-1:0] > FRAC_W'(256)) ? FRAC_W'(256)
                                                             : pwdata[FRAC_W-1:0];
          end
          default: ;
        endcase
      end
    end
  end

  // read back
  always_comb begin
    case (reg_idx)
      REG_NUM_ZONES:  prdata = APB_DW'(cfg.nz);
      REG_SLOTS:      prdata = APB_DW'(cfg.spz);
      REG_BUCKET_B:   prdata = APB_DW'(cfg.bb);
      REG_STRIDE:     prdata = APB_DW'(cfg.stride);
      REG_BASE:       prdata = APB_DW'(cfg.base);
      REG_CLEAN_FRAC: prdata = APB_DW'(cfg.frac);
      default:        prdata = '0;
    endcase
  end

endmodule

// ===== design/zlbm_ctrl.sv =====
// request sequencer: map clear after reset, then accept, read, execute, deliver
module zlbm_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  zlbm_pkg::dp_status_t status,
  output zlbm_pkg::dp_cmd_t    cmd
);
  import zlbm_pkg::*;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_READ  = 3'd2;
  localparam logic [2:0] ST_EXEC  = 3'd3;
  localparam logic [2:0] ST_OUT   = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state and datapath commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    case (state)
      ST_CLEAR: begin
        cmd.clr_we = 1'b1;
        if (status.clr_done) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        cmd.rd_en  = 1'b1;
        state_next = ST_EXEC;
      end
      ST_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (!status.out_full) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

endmodule

// ===== design/zlbm_dp.sv =====
// datapath: bucket index, map ram, zone pointers, location math and result register
module zlbm_dp #(
  parameter int NUM_BUCKETS = zlbm_pkg::NUM_BUCKETS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [zlbm_pkg::S_TDATA_W-1:0] s_tdata,
  input  logic [zlbm_pkg::KIND_W-1:0]    s_tuser,
  input  zlbm_pkg::cfg_t                 cfg,
  input  logic                           restart,
  input  zlbm_pkg::dp_cmd_t              cmd,
  output zlbm_pkg::dp_status_t           status,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [zlbm_pkg::M_TDATA_W-1:0] m_tdata
);
  import zlbm_pkg::*;

  localparam int IW = $clog2(NUM_BUCKETS);

  // captured request
  logic [KIND_W-1:0]   kind_r;
  logic [BUCKET_W-1:0] bkt_r;
  logic                wok_r;

  // map index
  logic [IW-1:0] idx_now;
  logic [IW-1:0] idx_r;
  logic [IW-1:0] clr_cnt;

  // map ram ports
  logic              map_we;
  logic [IW-1:0]     ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;
  map_entry_t        rd_entry;
  map_entry_t        ex_entry;
  logic              ex_we;

  // pointers
  logic [ZONE_W-1:0] write_zone, write_zone_next;
  logic [SLOT_W-1:0] write_slot, write_slot_next;
  logic [ZONE_W-1:0] erase_zone, erase_zone_next;

  // execute results
  logic              e_ok, e_unm, e_loc_en, e_rst, e_fin;
  logic [ZONE_W-1:0] e_zone;
  logic [SLOT_W-1:0] e_slot;
  logic [SLOT_W:0]   slot_inc;

  logic              r_ok, r_unm, r_loc_en, r_rst, r_fin;
  logic [ZONE_W-1:0] r_zone;
  logic [SLOT_W-1:0] r_slot;
  logic [SLOT_W+BB_W-1:0]   prod_s;
  logic [ZONE_W+STRIDE_W-1:0] prod_z;

  // result assembly
  logic [NZ_W-1:0]       free_z;
  logic [NZ_W+8-1:0]     free_scaled;
  logic [NZ_W+FRAC_W-1:0] thresh;
  logic                  clean;
  logic [LOC_W-1:0]      loc_sum;
  logic [LOC_W-1:0]      loc;

  function automatic logic [ZONE_W-1:0] next_zone(input logic [ZONE_W-1:0] z,
                                                  input logic [NZ_W-1:0] nz);
    logic [NZ_W-1:0] z1;
    z1 = {1'b0, z} + NZ_W'(1);
    return (z1 >= nz) ? '0 : z1[ZONE_W-1:0];
  endfunction

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r <= s_tuser;
      bkt_r  <= s_tdata[BUCKET_W-1:0];
      wok_r  <= s_tdata[BUCKET_W];
    end
  end

  // bucket reduced modulo the map depth
  generate
    if (NUM_BUCKETS >= (1 << BUCKET_W)) begin : g_idx_wide
      assign idx_now = IW'(bkt_r);
    end else if ((NUM_BUCKETS & (NUM_BUCKETS - 1)) == 0) begin : g_idx_pow2
      assign idx_now = bkt_r[IW-1:0];
    end else begin : g_idx_recip
      localparam int K  = 24;
      localparam int RW = K + 1;
      localparam logic [RW-1:0]       RECIP = RW'((1 << K) / NUM_BUCKETS);
      localparam logic [BUCKET_W-1:0] NB    = BUCKET_W'(NUM_BUCKETS);
      logic [BUCKET_W+RW-1:0] q_prod;
      logic [BUCKET_W-1:0]    q_est;
      logic [BUCKET_W-1:0]    qn;
      logic [BUCKET_W-1:0]    rem0;
      logic [BUCKET_W-1:0]    rem1;

      // quotient estimate, at most one low
      assign q_prod = (BUCKET_W+RW)'(s_tdata[BUCKET_W-1:0]) * (BUCKET_W+RW)'(RECIP);
      always_ff @(posedge clk) begin
        if (cmd.load) q_est <= q_prod[K +: BUCKET_W];
      end

      // remainder with one correction step
      assign qn      = BUCKET_W'(q_est * NB);
      assign rem0    = bkt_r - qn;
      assign rem1    = (rem0 >= NB) ? rem0 - NB : rem0;
      assign idx_now = rem1[IW-1:0];
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (cmd.rd_en) idx_r <= idx_now;
  end

  // clearing pass counter
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clr_we) begin
      clr_cnt <= clr_cnt + IW'(1);
    end
  end

  assign status.clr_done = (clr_cnt == IW'(NUM_BUCKETS - 1));
  assign status.out_full = m_tvalid & ~m_tready;

  // map ram
  assign map_we    = cmd.clr_we | (cmd.exec & ex_we);
  assign ram_waddr = cmd.clr_we ? clr_cnt : idx_r;
  assign ram_wdata = cmd.clr_we ? '0 : ex_entry;
  assign rd_entry  = ram_rdata;

  zlbm_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NUM_BUCKETS),
    .AW    (IW)
  ) u_map (
    .clk   (clk),
    .we    (map_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.rd_en),
    .raddr (idx_now),
    .rdata (ram_rdata)
  );

  // execute step: decide result and pointer moves
  assign slot_inc = {1'b0, write_slot} + (SLOT_W + 1)'(1);

  always_comb begin
    e_ok            = 1'b1;
    e_unm           = 1'b0;
    e_zone          = '0;
    e_slot          = '0;
    e_loc_en        = 1'b0;
    e_rst           = 1'b0;
    e_fin           = 1'b0;
    ex_we           = 1'b0;
    ex_entry        = '0;
    write_zone_next = write_zone;
    write_slot_next = write_slot;
    erase_zone_next = erase_zone;
    case (kind_r)
      KIND_WRITE: begin
        if (write_zone == erase_zone) begin
          e_ok = 1'b0;
        end else begin
          e_zone         = write_zone;
          e_slot         = write_slot;
          e_loc_en       = 1'b1;
          e_rst          = (write_slot == '0);
          e_ok           = wok_r;
          ex_we          = 1'b1;
          ex_entry.valid = wok_r;
          ex_entry.zone  = write_zone;
          ex_entry.slot  = write_slot;
          e_fin          = !wok_r || (slot_inc >= cfg.spz);
          if (e_fin) begin
            write_zone_next = next_zone(write_zone, cfg.nz);
            write_slot_next = '0;
          end else begin
            write_slot_next = slot_inc[SLOT_W-1:0];
          end
        end
      end
      KIND_READ: begin
        if (rd_entry.valid) begin
          e_zone   = rd_entry.zone;
          e_slot   = rd_entry.slot;
          e_loc_en = 1'b1;
        end else begin
          e_unm = 1'b1;
        end
      end
      KIND_ERASE: begin
        e_zone          = erase_zone;
        e_loc_en        = 1'b1;
        erase_zone_next = next_zone(erase_zone, cfg.nz);
      end
      KIND_INVAL: begin
        ex_we = 1'b1;
      end
      default: ;
    endcase
  end

  // zone pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      write_zone <= '0;
      write_slot <= '0;
      erase_zone <= ZONE_W'(RST_NUM_ZONES - NZ_W'(1));
    end else if (restart) begin
      write_zone <= '0;
      write_slot <= '0;
      erase_zone <= ZONE_W'(cfg.nz - NZ_W'(1));
    end else if (cmd.exec) begin
      write_zone <= write_zone_next;
      write_slot <= write_slot_next;
      erase_zone <= erase_zone_next;
    end
  end

  // execute results and location products
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      r_ok     <= e_ok;
      r_unm    <= e_unm;
      r_zone   <= e_zone;
      r_slot   <= e_slot;
      r_loc_en <= e_loc_en;
      r_rst    <= e_rst;
      r_fin    <= e_fin;
      prod_s   <= (SLOT_W+BB_W)'(e_slot) * (SLOT_W+BB_W)'(cfg.bb);
      prod_z   <= (ZONE_W+STRIDE_W)'(e_zone) * (ZONE_W+STRIDE_W)'(cfg.stride);
    end
  end

  // free zones against threshold, location sum
  assign free_z      = (erase_zone >= write_zone)
                       ? {1'b0, erase_zone} - {1'b0, write_zone}
                       : {1'b0, erase_zone} + cfg.nz - {1'b0, write_zone};
  assign free_scaled = {free_z, 8'b0};
  assign thresh      = (NZ_W+FRAC_W)'(cfg.frac) * (NZ_W+FRAC_W)'(cfg.nz);
  assign clean       = ({1'b0, free_scaled} <= thresh);
  assign loc_sum     = LOC_W'(cfg.base) + LOC_W'(prod_s) + LOC_W'(prod_z);
  assign loc         = r_loc_en ? loc_sum : '0;

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      m_tdata <= {1'b0, clean, r_fin, r_rst, loc, r_slot, r_zone, r_unm, r_ok};
    end
  end

endmodule

// ===== design/zoned_log_bucket_mapper_unit.sv =====
// top level of the zoned log bucket mapper
// Maps logical buckets onto slots of a ring of append-only zones and answers
// write, read, erase and invalidate requests with one result each. After reset
// the bucket map is swept clear, one entry per cycle across all NUM_BUCKETS
// entries (4096 by default), and s_tready stays low until the sweep ends;
// register writes are taken during the sweep. A request then goes through
// accept, map read on the ram's registered port (with the bucket reduced to
// the map depth), execute with pointer update, map write and the two
// location products, then the location sum and the clean flag into the
// output register. The next request is taken while a result still waits in
// the output register. Writing num_zones or slots_per_zone restarts the zone
// pointers in the cycle after the write; the map is kept.
module zoned_log_bucket_mapper_unit #(
  parameter int NUM_BUCKETS = zlbm_pkg::NUM_BUCKETS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // request stream
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // [11:0] bucket, [12] write_ok, [15:13] zero
  input  logic [zlbm_pkg::S_TDATA_W-1:0] s_tdata,
  // [1:0] kind
  input  logic [zlbm_pkg::KIND_W-1:0]    s_tuser,
  // result stream
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // [0] ok, [1] unmapped, [9:2] zone, [19:10] slot, [67:20] location,
  // [68] reset_zone, [69] finish_zone, [70] clean_needed, [71] zero
  output logic [zlbm_pkg::M_TDATA_W-1:0] m_tdata,
  // configuration port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [zlbm_pkg::APB_AW-1:0]    paddr,
  input  logic [zlbm_pkg::APB_DW-1:0]    pwdata,
  output logic [zlbm_pkg::APB_DW-1:0]    prdata,
  output logic                           pready
);
  import zlbm_pkg::*;

  cfg_t       cfg;
  logic       restart;
  dp_cmd_t    cmd;
  dp_status_t status;

  // configuration registers
  zlbm_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg),
    .restart (restart)
  );

  // sequencer
  zlbm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // datapath
  zlbm_dp #(
    .NUM_BUCKETS (NUM_BUCKETS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .cfg      (cfg),
    .restart  (restart),
    .cmd      (cmd),
    .status   (status),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

// ===== design/zlbm_checker.sv =====
// port level checks for the zoned log bucket mapper, bound to the top level
module zlbm_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tvalid,
  input logic                           s_tready,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [zlbm_pkg::M_TDATA_W-1:0] m_tdata
);
  import zlbm_pkg::*;

  logic             o_ok, o_unm, o_rst, o_fin;
  logic [ZONE_W-1:0] o_zone;
  logic [SLOT_W-1:0] o_slot;
  logic [LOC_W-1:0]  o_loc;

  assign o_ok   = m_tdata[OB_OK];
  assign o_unm  = m_tdata[OB_UNM];
  assign o_zone = m_tdata[OB_ZONE +: ZONE_W];
  assign o_slot = m_tdata[OB_SLOT +: SLOT_W];
  assign o_loc  = m_tdata[OB_LOC +: LOC_W];
  assign o_rst  = m_tdata[OB_RST];
  assign o_fin  = m_tdata[OB_FIN];

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // one request in flight at a time
  a_single: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request taken while another is in flight");

  // unmapped read carries ok and no position
  a_unmapped: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && o_unm |-> o_ok && o_loc == '0 && o_zone == '0 && o_slot == '0
                          && !o_rst && !o_fin)
    else $error("unmapped result with position or write flags");

  // refused write reports nothing
  a_refused: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !o_ok && !o_fin |-> !o_unm && !o_rst && o_loc == '0
                                    && o_zone == '0 && o_slot == '0)
    else $error("refused write with position");

endmodule

bind zoned_log_bucket_mapper_unit zlbm_checker u_zlbm_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
